@@ rtl/epc_pkg.sv @@
// ----------------------------------------------------------------------------
// epc_pkg
// Shared constants, command codes and controller-to-datapath command bundle
// for the encoder position controller.
// ----------------------------------------------------------------------------
package epc_pkg;

	// Default build values
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int PWM_TOP_DEF     = 400;

	// Fixed field widths
	localparam int FUNC_W     = 2;
	localparam int TARGET_W   = 32;
	localparam int POS_W      = 32;
	localparam int ERR_W      = 33;
	localparam int GAIN_W     = 16;
	localparam int DB_W       = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
	localparam logic [DB_W-1:0]   DB_RESET   = 9'd0;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DB   = 1'b1;

	// Request kinds
	localparam logic [FUNC_W-1:0] FUNC_CHA  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CHB  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CTRL = 2'd3;

	// One enable per datapath step
	typedef struct packed {
		logic load;     // capture request payload
		logic cnt_en;   // apply encoder / clear event
		logic err_en;   // error and saturation
		logic mul1_en;  // error times gain
		logic mag_en;   // effort magnitude and direction
		logic mul2_en;  // magnitude times duty slope
		logic div_en;   // divide by PWM top (reciprocal)
		logic duty_en;  // dead band offset and clamp
		logic out_load; // load result register
	} cmd_t;

endpackage

@@ rtl/encoder_position_p_controller_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_position_p_controller_unit
// Encoder and clear requests pass CNT and PUSH; control steps pass ERR, MUL1,
// MAG, MUL2, DIV, DUTY and PUSH before the result reaches the master side.
// The sequencer takes one request at a time through one shared datapath;
// PUSH waits while an untaken result is held, and the next request is taken
// while a finished result waits. Reset (arst_n low, asynchronous) clears the
// count, phase flags, error, direction, duty and restores gain 1.0 and dead band 0.
// ----------------------------------------------------------------------------
module encoder_position_p_controller_unit #(
	parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEF, // 16..48
	parameter int PWM_TOP     = epc_pkg::PWM_TOP_DEF,     // 64..1023
	localparam int DUTY_W     = $clog2(PWM_TOP + 1),
	localparam int OUT_W      = ((epc_pkg::POS_W + epc_pkg::ERR_W + 1 + DUTY_W + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [epc_pkg::TARGET_W-1:0]        s_tdata,  // [31:0] target
	input  logic [epc_pkg::FUNC_W-1:0]          s_tuser,  // [1:0] func
	// result side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [OUT_W-1:0]                    m_tdata,  // position, error, forward, duty, zero pad
	// configuration
	input  logic                                cfg_we,
	input  logic [epc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [epc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	epc_pkg::cmd_t                     cmd;
	logic [epc_pkg::POS_W-1:0]         position;
	logic signed [epc_pkg::ERR_W-1:0]  error;
	logic                              forward;
	logic [DUTY_W-1:0]                 duty;

	// Sequencer: one request at a time, one datapath step per cycle unless PUSH waits for the result register
	epc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath: counter, error, two multiplies, reciprocal divide, clamp
	epc_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.PWM_TOP     (PWM_TOP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (s_tuser),
		.target    ($signed(s_tdata)),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.position  (position),
		.error     (error),
		.forward   (forward),
		.duty      (duty)
	);

	// Pack result fields from the lowest bit up, zero pad to whole bytes
	assign m_tdata = OUT_W'({duty, forward, error, position});

`ifndef SYNTHESIS
	// a taken request blocks acceptance in the cycle right after it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted on back-to-back cycles");

	// the result register is only reloaded once it is empty or being taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	// duty never leaves the compare range
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (duty <= DUTY_W'(PWM_TOP)))
		else $error("duty above PWM top");
`endif

endmodule

@@ rtl/epc_ctrl.sv @@
// ----------------------------------------------------------------------------
// epc_ctrl
// Sequencer: accepts one request, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module epc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [epc_pkg::FUNC_W-1:0] func,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output epc_pkg::cmd_t              cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CNT  = 4'd1;
	localparam logic [3:0] ST_ERR  = 4'd2;
	localparam logic [3:0] ST_MUL1 = 4'd3;
	localparam logic [3:0] ST_MAG  = 4'd4;
	localparam logic [3:0] ST_MUL2 = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_DUTY = 4'd7;
	localparam logic [3:0] ST_PUSH = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       mvalid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = (func == epc_pkg::FUNC_CTRL) ? ST_ERR : ST_CNT;
				end
			end
			ST_CNT: begin
				cmd.cnt_en = 1'b1;
				state_d    = ST_PUSH;
			end
			ST_ERR: begin
				cmd.err_en = 1'b1;
				state_d    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag_en = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_d    = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.duty_en = 1'b1;
				state_d     = ST_PUSH;
			end
			ST_PUSH: begin
				// hold until the result register is free
				if (!mvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = mvalid_q;

endmodule

@@ rtl/epc_datapath.sv @@
// ----------------------------------------------------------------------------
// epc_datapath
// Position counter, control arithmetic, configuration and result registers.
// ----------------------------------------------------------------------------
module epc_datapath #(
	parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEF,
	parameter int PWM_TOP     = epc_pkg::PWM_TOP_DEF,
	localparam int DUTY_W     = $clog2(PWM_TOP + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  epc_pkg::cmd_t                         cmd,
	input  logic [epc_pkg::FUNC_W-1:0]            func,
	input  logic signed [epc_pkg::TARGET_W-1:0]   target,
	input  logic                                  cfg_we,
	input  logic [epc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [epc_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [epc_pkg::POS_W-1:0]             position,
	output logic signed [epc_pkg::ERR_W-1:0]      error,
	output logic                                  forward,
	output logic [DUTY_W-1:0]                     duty
);

	localparam int CW     = COUNT_WIDTH;
	localparam int EW     = ((CW > epc_pkg::TARGET_W) ? CW : epc_pkg::TARGET_W) + 1;
	localparam int PROD_W = epc_pkg::ERR_W + epc_pkg::GAIN_W + 1;
	localparam int MAG_SAT = PWM_TOP * 512;
	localparam int MW     = $clog2(MAG_SAT + 1);
	localparam int TW     = $clog2(PWM_TOP + 1);
	localparam int DW     = (TW > epc_pkg::DB_W) ? TW : epc_pkg::DB_W;
	localparam int N      = MW + DW;
	localparam int L      = $clog2(PWM_TOP);
	localparam int S      = N + L;
	localparam int RW     = N + 2;
	localparam int XW     = N + RW;
	localparam int QW     = XW - S;
	localparam int SW     = QW + 1;
	localparam logic [63:0] RECIP64 =
		((64'd1 << S) + 64'(PWM_TOP) - 64'd1) / 64'(PWM_TOP);
	localparam logic [RW-1:0] RECIP = RW'(RECIP64);
	localparam logic signed [EW-1:0] ERR_HI = EW'($signed({1'b0, {32{1'b1}}}));
	localparam logic signed [EW-1:0] ERR_LO = -ERR_HI;

	// configuration
	logic [epc_pkg::GAIN_W-1:0] gain_q;
	logic [epc_pkg::DB_W-1:0]   db_q;

	// state
	logic [epc_pkg::FUNC_W-1:0]        func_q;
	logic signed [epc_pkg::TARGET_W-1:0] target_q;
	logic [CW-1:0]                     count_q;
	logic                              pha_q;
	logic                              phb_q;
	logic signed [epc_pkg::ERR_W-1:0]  err_q;
	logic                              dir_q;
	logic [DUTY_W-1:0]                 duty_q;

	// working registers
	logic signed [PROD_W-1:0] prod_q;
	logic [MW-1:0]            mag_q;
	logic                     neg_q;
	logic [DW-1:0]            dmag_q;
	logic [N-1:0]             x_q;
	logic [QW-1:0]            quo_q;

	// result register
	logic [epc_pkg::POS_W-1:0]        out_pos_q;
	logic signed [epc_pkg::ERR_W-1:0] out_err_q;
	logic                             out_fwd_q;
	logic [DUTY_W-1:0]                out_duty_q;

	// combinational
	logic                      up;
	logic signed [EW-1:0]      diff_full;
	logic signed [epc_pkg::ERR_W-1:0] err_sat;
	logic signed [PROD_W-1:0]  prod_adj;
	logic signed [PROD_W-1:0]  eff;
	logic [PROD_W-1:0]         mag_full;
	logic [MW-1:0]             mag_sat;
	logic                      db_over;
	logic [DW-1:0]             dmag;
	logic [XW-1:0]             recip_prod;
	logic [SW-1:0]             val;
	logic [SW-1:0]             top_ext;
	logic [SW-1:0]             db_ext;
	logic [DUTY_W-1:0]         duty_next;

	assign up = (func_q == epc_pkg::FUNC_CHA) ? (~pha_q != phb_q) : (pha_q == ~phb_q);

	// error, saturated to +-(2^32 - 1)
	always_comb begin
		diff_full = EW'(target_q) - EW'($signed(count_q));
		if (diff_full > ERR_HI) begin
			err_sat = epc_pkg::ERR_W'(ERR_HI);
		end else if (diff_full < ERR_LO) begin
			err_sat = epc_pkg::ERR_W'(ERR_LO);
		end else begin
			err_sat = epc_pkg::ERR_W'(diff_full);
		end
	end

	// effort = product / 256 toward zero; clip magnitude where the clamp decides anyway
	always_comb begin
		prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
		eff      = prod_adj >>> 8;
		mag_full = eff[PROD_W-1] ? PROD_W'(-eff) : PROD_W'(eff);
		mag_sat  = (mag_full > PROD_W'(MAG_SAT)) ? MW'(MAG_SAT) : mag_full[MW-1:0];
		db_over  = DW'(db_q) > DW'(PWM_TOP);
		dmag     = db_over ? (DW'(db_q) - DW'(PWM_TOP)) : (DW'(PWM_TOP) - DW'(db_q));
	end

	assign recip_prod = XW'(x_q) * XW'(RECIP);

	// dead band offset and clamp to 0..PWM_TOP
	always_comb begin
		top_ext = SW'(PWM_TOP);
		db_ext  = SW'(db_q);
		if (neg_q) begin
			val = (SW'(quo_q) >= db_ext) ? '0 : (db_ext - SW'(quo_q));
		end else begin
			val = SW'(quo_q) + db_ext;
		end
		duty_next = (val > top_ext) ? DUTY_W'(PWM_TOP) : DUTY_W'(val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= epc_pkg::GAIN_RESET;
			db_q    <= epc_pkg::DB_RESET;
			count_q <= '0;
			pha_q   <= 1'b0;
			phb_q   <= 1'b0;
			err_q   <= '0;
			dir_q   <= 1'b0;
			duty_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					epc_pkg::CFG_GAIN: gain_q <= cfg_data;
					epc_pkg::CFG_DB:   db_q   <= cfg_data[epc_pkg::DB_W-1:0];
					default: ;
				endcase
			end
			if (cmd.cnt_en) begin
				case (func_q)
					epc_pkg::FUNC_CHA: begin
						pha_q   <= ~pha_q;
						count_q <= up ? count_q + CW'(1) : count_q - CW'(1);
					end
					epc_pkg::FUNC_CHB: begin
						phb_q   <= ~phb_q;
						count_q <= up ? count_q + CW'(1) : count_q - CW'(1);
					end
					epc_pkg::FUNC_CLR: begin
						count_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.err_en) begin
				err_q <= err_sat;
			end
			if (cmd.mag_en) begin
				dir_q <= ~eff[PROD_W-1];
			end
			if (cmd.duty_en) begin
				duty_q <= duty_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			target_q <= target;
		end
		if (cmd.mul1_en) begin
			prod_q <= PROD_W'(err_q) * PROD_W'($signed({1'b0, gain_q}));
		end
		if (cmd.mag_en) begin
			mag_q  <= mag_sat;
			neg_q  <= db_over;
			dmag_q <= dmag;
		end
		if (cmd.mul2_en) begin
			x_q <= N'(mag_q) * N'(dmag_q);
		end
		if (cmd.div_en) begin
			quo_q <= recip_prod[XW-1:S];
		end
		if (cmd.out_load) begin
			out_pos_q  <= epc_pkg::POS_W'(count_q);
			out_err_q  <= err_q;
			out_fwd_q  <= dir_q;
			out_duty_q <= duty_q;
		end
	end

	assign position = out_pos_q;
	assign error    = out_err_q;
	assign forward  = out_fwd_q;
	assign duty     = out_duty_q;

endmodule

@@ tb/tb_encoder_position_p_controller_unit.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_position_p_controller_unit
// Self-checking bench for the encoder position controller. A queue-fed driver
// sends encoder, clear and control-step requests with random gaps. A shadow
// model tracks count, phase flags and drive outputs per accepted request.
// The monitor compares every result field against the oldest expected entry
// while the result side stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_encoder_position_p_controller_unit;
	import epc_pkg::*;

	localparam int OUT_W      = 80;
	localparam int DUTY_W     = 9;
	localparam int DUTY_LSB   = POS_W + ERR_W + 1;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 400;
	localparam longint ERR_SAT = 64'sd4294967295;

	typedef struct {
		logic [FUNC_W-1:0]   func;
		logic [TARGET_W-1:0] target;
	} servo_req_t;

	typedef struct {
		logic [POS_W-1:0]  position;
		logic [ERR_W-1:0]  error;
		logic              fwd;
		logic [DUTY_W-1:0] duty;
	} servo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TARGET_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0] s_tuser = FUNC_CHA;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Stimulus and scoreboard storage
	servo_req_t    request_q[$];
	servo_result_t expected_results[$];
	servo_req_t    next_req;
	int            mismatch_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            idle_cycles = 0;
	int            stall_left = 0;
	bit            hold_arm = 1'b0;
	bit            hold_taken = 1'b0;

	// Shadow of the block's state and registers
	logic signed [POS_W-1:0] pos_count = '0;
	logic                    ph_a = 1'b0;
	logic                    ph_b = 1'b0;
	longint                  held_error = 0;
	logic                    held_fwd = 1'b0;
	logic [DUTY_W-1:0]       held_duty = '0;
	logic [GAIN_W-1:0]       gain_shadow = GAIN_RESET;
	logic [DB_W-1:0]         db_shadow = DB_RESET;

	encoder_position_p_controller_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),  // [31:0] target
		.s_tuser  (s_tuser),  // [1:0] func
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),  // [31:0] position, [64:32] error, [65] forward, [74:66] duty
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Advance the shadow state by one accepted request and queue the result
	// the block must produce for it.
	task automatic track_request(input logic [FUNC_W-1:0] fn, input logic [TARGET_W-1:0] tgt);
		longint err;
		longint effort;
		longint mag;
		longint db;
		longint duty;
		servo_result_t r;
		case (fn)
			FUNC_CHA: begin
				ph_a = ~ph_a;
				// count up when A leads B, down otherwise
				if (ph_a != ph_b) pos_count = pos_count + 1;
				else pos_count = pos_count - 1;
			end
			FUNC_CHB: begin
				ph_b = ~ph_b;
				if (ph_a == ph_b) pos_count = pos_count + 1;
				else pos_count = pos_count - 1;
			end
			FUNC_CLR: begin
				// only the count clears; phases and drive outputs hold
				pos_count = '0;
			end
			default: begin
				err = longint'($signed(tgt)) - longint'(pos_count);
				if (err > ERR_SAT) err = ERR_SAT;
				if (err < -ERR_SAT) err = -ERR_SAT;
				held_error = err;
				// Q8.8 gain, division truncates toward zero
				effort = (err * longint'(gain_shadow)) / 256;
				held_fwd = (effort >= 0);
				mag = (effort < 0) ? -effort : effort;
				db = longint'(db_shadow);
				// zero effort still maps to the dead band; slope turns negative
				// when the dead band exceeds the top, clamp catches both ends
				duty = (mag * (PWM_TOP_DEF - db)) / PWM_TOP_DEF + db;
				if (duty < 0) duty = 0;
				if (duty > PWM_TOP_DEF) duty = PWM_TOP_DEF;
				held_duty = duty[DUTY_W-1:0];
			end
		endcase
		r.position = pos_count;
		r.error = held_error[ERR_W-1:0];
		r.fwd = held_fwd;
		r.duty = held_duty;
		expected_results.push_back(r);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] data);
		servo_result_t want;
		servo_result_t got;
		got.position = data[POS_W-1:0];
		got.error = data[POS_W +: ERR_W];
		got.fwd = data[POS_W + ERR_W];
		got.duty = data[DUTY_LSB +: DUTY_W];
		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: result with no request outstanding: pos %0d err %0h",
					$realtime, $signed(got.position), got.error);
		end else begin
			want = expected_results.pop_front();
			if (got.position !== want.position || got.error !== want.error ||
					got.fwd !== want.fwd || got.duty !== want.duty) begin
				mismatch_count++;
				// each pair prints as expected/actual
				if (mismatch_count <= 10)
					$display("%0t: mismatch pos %0d/%0d err %0h/%0h fwd %0b/%0b duty %0d/%0d",
						$realtime,
						$signed(want.position), $signed(got.position), want.error,
						got.error, want.fwd, got.fwd, want.duty, got.duty);
			end
		end
	endtask

	// Driver: record the request just accepted, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FUNC_CHA;
		end else begin
			if (s_tvalid && s_tready) track_request(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.target;
					s_tuser <= next_req.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result, stall the result side at random,
	// and hold off once for a long stretch so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_result(m_tdata);
			if (hold_arm && !hold_taken) begin
				hold_taken <= 1'b1;
				stall_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[encoder_position_p_controller_unit] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_req(input logic [FUNC_W-1:0] fn, input logic [TARGET_W-1:0] tgt);
		servo_req_t r;
		r.func = fn;
		r.target = tgt;
		request_q.push_back(r);
	endtask

	// Random requests: mostly encoder runs and near-range control steps,
	// with clears and full-range targets mixed in
	task automatic push_random(input int n);
		int pick;
		int run;
		logic [TARGET_W-1:0] tgt;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			tgt = $urandom;
			if (pick < 15) begin
				// alternating A/B keeps one direction for the whole run
				run = $urandom_range(4, 16);
				for (int k = 0; k < run; k++)
					push_req(((k % 2) == 0) ? FUNC_CHA : FUNC_CHB, $urandom);
				i += run - 1;
			end else if (pick < 35) begin
				push_req(FUNC_CHA, tgt);
			end else if (pick < 55) begin
				push_req(FUNC_CHB, tgt);
			end else if (pick < 60) begin
				push_req(FUNC_CLR, tgt);
			end else begin
				if ($urandom_range(99) < 70) tgt = $urandom_range(1600) - 800;
				push_req(FUNC_CTRL, tgt);
			end
		end
	endtask

	// Wait until every request is sent and every result is back, then let
	// the datapath settle
	task automatic drain();
		while (request_q.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_regs(input logic [GAIN_W-1:0] gain, input logic [DB_W-1:0] db);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cfg_index <= CFG_DB;
		// upper bits beyond the dead band width are dropped by the block
		cfg_data <= {7'($urandom), db};
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_shadow = gain;
		db_shadow = db;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [GAIN_W-1:0] gain, input logic [DB_W-1:0] db,
			input int send_pct, input int recv_pct, input int n,
			input bit pause, input bit hold);
		drain();
		write_regs(gain, db);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		push_random(n / 2);
		if (hold) hold_arm = 1'b1;
		// sender pause: hold further requests until the block is empty
		if (pause) drain();
		push_random(n - n / 2);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: quadrature both ways, clears, zero effort, target extremes
		push_req(FUNC_CTRL, 32'd0);
		push_req(FUNC_CHA, 32'hFFFF_FFFF);
		push_req(FUNC_CHB, 32'd0);
		push_req(FUNC_CHA, 32'd0);
		push_req(FUNC_CHB, 32'hFFFF_FFFF);
		push_req(FUNC_CTRL, 32'h7FFF_FFFF);
		push_req(FUNC_CTRL, 32'h8000_0000);
		push_req(FUNC_CTRL, 32'd4);
		push_req(FUNC_CLR, 32'h5555_5555);
		push_req(FUNC_CHB, 32'hAAAA_AAAA);
		push_req(FUNC_CHA, 32'd0);
		push_req(FUNC_CTRL, 32'h7FFF_FFFF);
		push_req(FUNC_CTRL, 32'h8000_0000);
		push_req(FUNC_CTRL, -32'sd2);
		push_req(FUNC_CTRL, -32'sd3);
		push_req(FUNC_CLR, 32'd0);
		push_req(FUNC_CTRL, 32'd0);
		push_req(FUNC_CTRL, 32'd400);
		push_req(FUNC_CTRL, -32'sd400);
		push_req(FUNC_CTRL, 32'd401);
		push_req(FUNC_CHA, 32'd0);
		push_req(FUNC_CHB, 32'd0);
		push_req(FUNC_CTRL, 32'd1);
		push_random(330);

		// Register settings from extreme to typical, one idling mode each
		run_phase(16'd0, 9'd400, 70, 0, 330, 1'b1, 1'b0);
		run_phase(16'hFFFF, 9'd0, 0, 70, 330, 1'b0, 1'b0);
		run_phase(16'($urandom), 9'd511, 15, 15, 330, 1'b0, 1'b0);
		run_phase(16'd256, 9'($urandom_range(400)), 0, 0, 330, 1'b0, 1'b1);
		run_phase(16'd1, 9'd200, 15, 15, 330, 1'b0, 1'b0);

		drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("[encoder_position_p_controller_unit] OK");
		else
			$display("[encoder_position_p_controller_unit] ERROR");
		$finish;
	end

endmodule
